[src/ttrs_pkg.sv]
// ttrs_pkg: shared widths, codes and constants for the throttle ramp sequencer
// used by the channel interfaces and by the top level; no dependencies
`default_nettype none

package ttrs_pkg;

	localparam int W_ACT      = 3;
	localparam int W_TIME     = 32;
	localparam int W_THR      = 16;
	localparam int W_PULSE    = 11;
	localparam int W_PHASE    = 2;
	localparam int W_CAL      = 2;
	localparam int W_CFG_IDX  = 2;
	localparam int W_CFG_DATA = 32;
	localparam int W_PROD     = 26;

	typedef enum logic [W_ACT-1:0] {
		ACT_TICK   = 3'd0,
		ACT_TOGGLE = 3'd1,
		ACT_CAL    = 3'd2,
		ACT_UP     = 3'd3,
		ACT_DOWN   = 3'd4,
		ACT_SET    = 3'd5
	} action_t;

	typedef enum logic [W_CFG_IDX-1:0] {
		REG_CAP      = 2'd0,
		REG_STEP     = 2'd1,
		REG_HOLD     = 2'd2,
		REG_INTERVAL = 2'd3
	} cfg_reg_t;

	localparam logic [W_PHASE-1:0] PH_STOP = 2'd0;
	localparam logic [W_PHASE-1:0] PH_UP   = 2'd1;
	localparam logic [W_PHASE-1:0] PH_TOP  = 2'd2;
	localparam logic [W_PHASE-1:0] PH_DOWN = 2'd3;

	localparam logic [W_CAL-1:0] CAL_NORMAL = 2'd0;
	localparam logic [W_CAL-1:0] CAL_FULL   = 2'd1;
	localparam logic [W_CAL-1:0] CAL_MIN    = 2'd2;

	localparam logic [W_THR-1:0]  THR_MAX   = 16'd65535;
	localparam logic [W_THR-1:0]  NUDGE_Q16 = 16'd328;

	localparam logic [W_PULSE-1:0] PULSE_MIN   = 11'd1000;
	localparam logic [W_PULSE-1:0] PULSE_MAX   = 11'd2000;
	localparam logic [9:0]         PULSE_SPAN  = 10'd1000;
	localparam logic [W_PROD-1:0]  PULSE_ROUND = 26'd32768;

	localparam logic [W_THR-1:0]  RST_CAP      = 16'd26214;
	localparam logic [W_THR-1:0]  RST_STEP     = 16'd66;
	localparam logic [W_TIME-1:0] RST_HOLD     = 32'd500000;
	localparam logic [W_TIME-1:0] RST_INTERVAL = 32'd20000;

endpackage

`default_nettype wire

[src/ttrs_if.sv]
// ttrs channel interfaces: command request, result and register write channels
// depends on ttrs_pkg for field widths
`default_nettype none

interface ttrs_cmd_if import ttrs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [W_ACT-1:0]   action;
	logic [W_TIME-1:0]  now_us;
	logic [W_THR-1:0]   set_value;

	modport source (output valid, action, now_us, set_value, input ready);
	modport sink   (input valid, action, now_us, set_value, output ready);
endinterface

interface ttrs_res_if import ttrs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [W_THR-1:0]   throttle_out;
	logic [W_PULSE-1:0] pulse_us;
	logic [W_PHASE-1:0] phase;
	logic [W_CAL-1:0]   cal_mode_out;

	modport source (output valid, throttle_out, pulse_us, phase, cal_mode_out, input ready);
	modport sink   (input valid, throttle_out, pulse_us, phase, cal_mode_out, output ready);
endinterface

interface ttrs_cfg_if import ttrs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [W_CFG_IDX-1:0]  index;
	logic [W_CFG_DATA-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/throttle_trapezoid_ramp_sequencer_top.sv]
// throttle_trapezoid_ramp_sequencer_top: trapezoid throttle sequencer with manual and cal events
// depends on ttrs_pkg and the channel interfaces in ttrs_if.sv
`default_nettype none

// One request per clock, sustained while the result side is ready. A request is captured in an
// input register, the whole sequencer state (run, ramp phase, hold timer reference, calibration
// mode) is updated together from it, and the ESC pulse width is formed in the next stage from
// the registered throttle and held in an output register with the other result fields.
// Register writes take effect at once and are accepted in every cycle.
module throttle_trapezoid_ramp_sequencer_top import ttrs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ttrs_cfg_if.sink     cfg,
	ttrs_cmd_if.sink     cmd,
	ttrs_res_if.source   res
);

	// configuration
	logic [W_THR-1:0]  cap_q;
	logic [W_THR-1:0]  step_q;
	logic [W_TIME-1:0] hold_q;
	logic [W_TIME-1:0] interval_q;

	// sequencer state
	logic [W_THR-1:0]  thr_q;
	logic              stopped_q;
	logic              active_q;
	logic              desc_q;
	logic              topd_q;
	logic [W_TIME-1:0] last_q;
	logic [W_CAL-1:0]  cal_q;

	// pipeline
	logic              valid_s1, valid_s2, valid_s3;
	logic [W_ACT-1:0]  action_s1;
	logic [W_TIME-1:0] now_s1;
	logic [W_THR-1:0]  setv_s1;
	logic [W_THR-1:0]  thr_s2;
	logic              stopped_s2;
	logic [W_CAL-1:0]  cal_s2;
	logic [W_PHASE-1:0] phase_s2;
	logic [W_THR-1:0]  thr_s3;
	logic [W_PULSE-1:0] pulse_s3;
	logic [W_PHASE-1:0] phase_s3;
	logic [W_CAL-1:0]  cal_s3;

	logic en1, en2, en3;

	// next state
	logic [W_THR-1:0]  thr_n;
	logic              stopped_n;
	logic              active_n;
	logic              desc_n;
	logic              topd_n;
	logic [W_TIME-1:0] last_n;
	logic [W_CAL-1:0]  cal_n;
	logic [W_PHASE-1:0] phase_n;
	logic [W_THR:0]    up_sum;
	logic [W_THR:0]    ramp_sum;
	logic [W_TIME-1:0] elapsed;
	logic              hold_fire;
	logic              step_go;

	logic [W_PROD-1:0] prod;
	logic [W_PULSE-1:0] pulse_n;

	// handshake
	assign en3       = !valid_s3 || res.ready;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign cmd.ready = en1;
	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= RST_CAP;
			step_q     <= RST_STEP;
			hold_q     <= RST_HOLD;
			interval_q <= RST_INTERVAL;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_CAP:      cap_q      <= cfg.data[W_THR-1:0];
				REG_STEP:     step_q     <= cfg.data[W_THR-1:0];
				REG_HOLD:     hold_q     <= cfg.data;
				REG_INTERVAL: interval_q <= cfg.data;
			endcase
		end
	end

	// event then ramp update
	always_comb begin
		thr_n     = thr_q;
		stopped_n = stopped_q;
		active_n  = active_q;
		desc_n    = desc_q;
		topd_n    = topd_q;
		last_n    = last_q;
		cal_n     = cal_q;
		up_sum    = {1'b0, thr_q} + {1'b0, NUDGE_Q16};
		ramp_sum  = '0;
		elapsed   = '0;
		hold_fire = 1'b0;
		step_go   = 1'b0;

		case (action_t'(action_s1))
			ACT_TOGGLE: begin
				stopped_n = !stopped_q;
				if (stopped_q) begin
					active_n = 1'b1;
					desc_n   = 1'b0;
					topd_n   = 1'b0;
					thr_n    = '0;
					last_n   = now_s1;
				end
			end
			ACT_CAL: cal_n = (cal_q >= CAL_MIN) ? CAL_NORMAL : cal_q + 2'd1;
			ACT_UP:  thr_n = up_sum[W_THR] ? THR_MAX : up_sum[W_THR-1:0];
			ACT_DOWN: thr_n = (thr_q > NUDGE_Q16) ? thr_q - NUDGE_Q16 : '0;
			ACT_SET: thr_n = setv_s1;
			default: ;
		endcase

		if (cal_n != CAL_NORMAL) begin
			thr_n = '0;
		end else begin
			if (active_n && !stopped_n) begin
				elapsed   = now_s1 - last_n;
				hold_fire = desc_n && !topd_n && (elapsed >= hold_q);
				step_go   = hold_fire ? (interval_q == '0) : (elapsed >= interval_q);
				if (hold_fire) begin
					topd_n = 1'b1;
					last_n = now_s1;
				end
				if (step_go) begin
					if (!desc_n) begin
						ramp_sum = {1'b0, thr_n} + {1'b0, step_q};
						last_n   = now_s1;
						if (ramp_sum[W_THR] || ramp_sum[W_THR-1:0] >= cap_q) begin
							thr_n  = cap_q;
							desc_n = 1'b1;
						end else begin
							thr_n = ramp_sum[W_THR-1:0];
						end
					end else if (topd_n) begin
						last_n = now_s1;
						if (thr_n <= step_q) begin
							thr_n     = '0;
							active_n  = 1'b0;
							stopped_n = 1'b1;
						end else begin
							thr_n = thr_n - step_q;
						end
					end
				end
			end
			if (stopped_n) begin
				thr_n    = '0;
				active_n = 1'b0;
				desc_n   = 1'b0;
			end
		end

		if (stopped_n || !active_n) phase_n = PH_STOP;
		else if (!desc_n)           phase_n = PH_UP;
		else if (!topd_n)           phase_n = PH_TOP;
		else                        phase_n = PH_DOWN;
	end

	// pulse width from the registered throttle
	always_comb begin
		prod = {{(W_PROD-W_THR){1'b0}}, thr_s2} * {{(W_PROD-10){1'b0}}, PULSE_SPAN} + PULSE_ROUND;
		if (cal_s2 == CAL_FULL)
			pulse_n = PULSE_MAX;
		else if (cal_s2 == CAL_MIN || stopped_s2)
			pulse_n = PULSE_MIN;
		else
			pulse_n = PULSE_MIN + {1'b0, prod[W_PROD-1:16]};
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			thr_q     <= '0;
			stopped_q <= 1'b1;
			active_q  <= 1'b0;
			desc_q    <= 1'b0;
			topd_q    <= 1'b0;
			last_q    <= '0;
			cal_q     <= CAL_NORMAL;
		end else begin
			if (en1) valid_s1 <= cmd.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en2 && valid_s1) begin
				thr_q     <= thr_n;
				stopped_q <= stopped_n;
				active_q  <= active_n;
				desc_q    <= desc_n;
				topd_q    <= topd_n;
				last_q    <= last_n;
				cal_q     <= cal_n;
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			action_s1 <= cmd.action;
			now_s1    <= cmd.now_us;
			setv_s1   <= cmd.set_value;
		end
		if (en2 && valid_s1) begin
			thr_s2     <= thr_n;
			stopped_s2 <= stopped_n;
			cal_s2     <= cal_n;
			phase_s2   <= phase_n;
		end
		if (en3 && valid_s2) begin
			thr_s3   <= thr_s2;
			pulse_s3 <= pulse_n;
			phase_s3 <= phase_s2;
			cal_s3   <= cal_s2;
		end
	end

	assign res.valid        = valid_s3;
	assign res.throttle_out = thr_s3;
	assign res.pulse_us     = pulse_s3;
	assign res.phase        = phase_s3;
	assign res.cal_mode_out = cal_s3;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> valid_s1)
		else $error("accepted request not captured");

	a_cal_zero_thr: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.cal_mode_out != CAL_NORMAL |-> res.throttle_out == '0)
		else $error("throttle nonzero during calibration");

	a_stop_zero_thr: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.phase == PH_STOP |-> res.throttle_out == '0)
		else $error("throttle nonzero while stopped");

	a_full_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.cal_mode_out == CAL_FULL |-> res.pulse_us == PULSE_MAX)
		else $error("full calibration pulse wrong");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for throttle_trapezoid_ramp_sequencer_top with a throttle
// ramp predictor, random event streams, register profiles and random stalls on both channels
// depends on ttrs_pkg, the channel interfaces in ttrs_if.sv and the top level

module testbench;
	import ttrs_pkg::*;

	localparam logic [W_ACT-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [W_ACT-1:0] ACT_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [W_THR-1:0]   throttle_out;
		logic [W_PULSE-1:0] pulse_us;
		logic [W_PHASE-1:0] phase;
		logic [W_CAL-1:0]   cal_mode_out;
	} ramp_result_t;

	class ramp_tracker;
		logic [W_THR-1:0]  cap;
		logic [W_THR-1:0]  step;
		logic [W_TIME-1:0] hold;
		logic [W_TIME-1:0] interval;
		logic [W_THR-1:0]  level;
		bit                stopped;
		bit                active;
		bit                desc;
		bit                top_done;
		logic [W_TIME-1:0] last_us;
		logic [W_CAL-1:0]  cal;
		ramp_result_t      expected_q[$];
		int                errors;
		int                checked;

		function new();
			cap = RST_CAP;
			step = RST_STEP;
			hold = RST_HOLD;
			interval = RST_INTERVAL;
			level = '0;
			stopped = 1'b1;
			active = 1'b0;
			desc = 1'b0;
			top_done = 1'b0;
			last_us = '0;
			cal = CAL_NORMAL;
			errors = 0;
			checked = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [W_CFG_DATA-1:0] data);
			case (idx)
				REG_CAP:      cap = data[W_THR-1:0];
				REG_STEP:     step = data[W_THR-1:0];
				REG_HOLD:     hold = data;
				REG_INTERVAL: interval = data;
				default: ;
			endcase
		endfunction

		function void take_command(logic [W_ACT-1:0] act, logic [W_TIME-1:0] stamp,
				logic [W_THR-1:0] setv);
			logic [W_THR:0]    sum;
			logic [W_TIME-1:0] elapsed;
			int unsigned       scaled;
			ramp_result_t      r;
			case (act)
				ACT_TOGGLE: begin
					stopped = !stopped;
					if (!stopped) begin
						active = 1'b1;
						desc = 1'b0;
						top_done = 1'b0;
						level = '0;
						last_us = stamp;
					end
				end
				ACT_CAL: cal = (cal == CAL_MIN) ? CAL_NORMAL : cal + 1'b1;
				ACT_UP: begin
					sum = level + NUDGE_Q16;
					level = (sum > THR_MAX) ? THR_MAX : sum[W_THR-1:0];
				end
				ACT_DOWN: level = (level > NUDGE_Q16) ? level - NUDGE_Q16 : '0;
				ACT_SET: level = setv;
				default: ;
			endcase
			if (cal != CAL_NORMAL) begin
				level = '0;
			end else begin
				if (active && !stopped) begin
					elapsed = stamp - last_us;
					if (desc && !top_done && elapsed >= hold) begin
						top_done = 1'b1;
						last_us = stamp;
						elapsed = '0;
					end
					if (elapsed >= interval) begin
						if (!desc) begin
							sum = level + step;
							last_us = stamp;
							if (sum > THR_MAX) sum = THR_MAX;
							if (sum >= cap) begin
								sum = cap;
								desc = 1'b1;
							end
							level = sum[W_THR-1:0];
						end else if (top_done) begin
							last_us = stamp;
							if (level <= step) begin
								level = '0;
								active = 1'b0;
								stopped = 1'b1;
							end else begin
								level = level - step;
							end
						end
					end
				end
				if (stopped) begin
					level = '0;
					active = 1'b0;
					desc = 1'b0;
				end
			end
			r.throttle_out = level;
			if (cal == CAL_FULL) begin
				r.pulse_us = PULSE_MAX;
			end else if (cal == CAL_MIN || stopped) begin
				r.pulse_us = PULSE_MIN;
			end else begin
				scaled = (level * PULSE_SPAN + PULSE_ROUND) >> 16;
				r.pulse_us = PULSE_MIN + scaled[W_PULSE-1:0];
			end
			if (stopped || !active) r.phase = PH_STOP;
			else if (!desc) r.phase = PH_UP;
			else if (!top_done) r.phase = PH_TOP;
			else r.phase = PH_DOWN;
			r.cal_mode_out = cal;
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("mismatch at result %0d: %s got %0d expected %0d", checked, what, got, want);
			errors++;
		endtask

		task check_output(ramp_result_t got);
			ramp_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with no request pending, throttle", got.throttle_out, 0);
			end else begin
				want = expected_q.pop_front();
				if (got.throttle_out !== want.throttle_out)
					report_mismatch("throttle_out", got.throttle_out, want.throttle_out);
				if (got.pulse_us !== want.pulse_us)
					report_mismatch("pulse_us", got.pulse_us, want.pulse_us);
				if (got.phase !== want.phase)
					report_mismatch("phase", got.phase, want.phase);
				if (got.cal_mode_out !== want.cal_mode_out)
					report_mismatch("cal_mode_out", got.cal_mode_out, want.cal_mode_out);
			end
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic [W_TIME-1:0] stamp_us;
	bit quiet;
	bit long_hold_req;
	ramp_tracker tracker;

	ttrs_cmd_if cmd_bus();
	ttrs_res_if res_bus();
	ttrs_cfg_if cfg_bus();

	throttle_trapezoid_ramp_sequencer_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.cmd(cmd_bus),
		.res(res_bus)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("throttle_trapezoid_ramp_sequencer_top verification failed");
		$finish;
	end

	always @(posedge clk) begin
		ramp_result_t got;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.throttle_out = res_bus.throttle_out;
			got.pulse_us = res_bus.pulse_us;
			got.phase = res_bus.phase;
			got.cal_mode_out = res_bus.cal_mode_out;
			tracker.check_output(got);
		end
	end

	// result side pacing: random stall bursts, one long hold-off on request
	initial begin
		int gap;
		int held;
		int window;
		bit bursty;
		gap = 0;
		window = 0;
		bursty = 1'b1;
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				res_bus.ready = 1'b0;
				for (held = 0; held < 300; held++) @(negedge clk);
				long_hold_req = 1'b0;
			end
			window++;
			if (window % 64 == 0) bursty = ($urandom_range(0, 4) != 0);
			if (!arst_n) begin
				res_bus.ready = 1'b0;
			end else if (gap > 0) begin
				res_bus.ready = 1'b0;
				gap--;
			end else begin
				res_bus.ready = 1'b1;
				if (!quiet && bursty && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
			end
		end
	end

	task automatic issue_command(input logic [W_ACT-1:0] act, input logic [W_TIME-1:0] stamp,
			input logic [W_THR-1:0] setv, input bit gaps);
		if (gaps && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
		cmd_bus.valid = 1'b1;
		cmd_bus.action = act;
		cmd_bus.now_us = stamp;
		cmd_bus.set_value = setv;
		do @(posedge clk); while (!cmd_bus.ready);
		tracker.take_command(act, stamp, setv);
		@(negedge clk);
		cmd_bus.valid = 1'b0;
	endtask

	task automatic poke_register(input cfg_reg_t idx, input logic [W_CFG_DATA-1:0] data);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data = data;
		do @(posedge clk); while (!cfg_bus.ready);
		tracker.set_register(idx, data);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// registers change only with nothing in flight
	task automatic load_profile(input logic [W_THR-1:0] cap, input logic [W_THR-1:0] step,
			input logic [W_TIME-1:0] hold, input logic [W_TIME-1:0] interval);
		while (tracker.expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		poke_register(REG_CAP, W_CFG_DATA'(cap));
		poke_register(REG_STEP, W_CFG_DATA'(step));
		poke_register(REG_HOLD, hold);
		poke_register(REG_INTERVAL, interval);
	endtask

	task automatic run_phase(input int items, input int unsigned dt_max, input int hold_at);
		int i;
		int roll;
		logic [W_ACT-1:0] act;
		for (i = 0; i < items; i++) begin
			if (i == hold_at) long_hold_req = 1'b1;
			roll = $urandom_range(0, 99);
			if (tracker.cal != CAL_NORMAL) begin
				if (roll < 30) act = ACT_CAL;
				else if (roll < 90) act = ACT_TICK;
				else act = W_ACT'($urandom_range(0, 7));
			end else if (tracker.stopped) begin
				if (roll < 25) act = ACT_TOGGLE;
				else if (roll < 32) act = W_ACT'($urandom_range(0, 7));
				else act = ACT_TICK;
			end else begin
				if (roll < 2) act = ACT_TOGGLE;
				else if (roll < 4) act = ACT_CAL;
				else if (roll < 7) act = ACT_UP;
				else if (roll < 10) act = ACT_DOWN;
				else if (roll < 13) act = ACT_SET;
				else if (roll < 14) act = ACT_SPARE_LO;
				else if (roll < 15) act = ACT_SPARE_HI;
				else act = ACT_TICK;
			end
			roll = $urandom_range(0, 99);
			// occasional wild jumps and the largest possible elapsed time
			if (roll < 3) stamp_us = stamp_us + $urandom();
			else if (roll < 5) stamp_us = tracker.last_us - 1'b1;
			else stamp_us = stamp_us + $urandom_range(0, dt_max);
			issue_command(act, stamp_us, W_THR'($urandom_range(0, 65535)),
				!quiet && ((i / 40) % 3 != 0));
		end
	endtask

	initial begin
		int k;
		int r;
		tracker = new();
		quiet = 1'b0;
		long_hold_req = 1'b0;
		stamp_us = '0;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.action = ACT_TICK;
		cmd_bus.now_us = '0;
		cmd_bus.set_value = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_CAP;
		cfg_bus.data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// manual events while stopped, saturation, calibration cycle, hold end, wrap
		issue_command(ACT_TICK, 32'd0, 16'd0, 1'b1);
		issue_command(ACT_UP, 32'd10, 16'd0, 1'b1);
		issue_command(ACT_SET, 32'd20, 16'hFFFF, 1'b1);
		issue_command(ACT_TOGGLE, 32'd100, 16'd0, 1'b1);
		issue_command(ACT_SET, 32'd200, 16'hFFFF, 1'b1);
		issue_command(ACT_UP, 32'd300, 16'd0, 1'b1);
		issue_command(ACT_DOWN, 32'd400, 16'd0, 1'b1);
		issue_command(ACT_SET, 32'd500, 16'd100, 1'b1);
		issue_command(ACT_DOWN, 32'd600, 16'd0, 1'b1);
		issue_command(ACT_DOWN, 32'd700, 16'd0, 1'b1);
		issue_command(ACT_UP, 32'd800, 16'd0, 1'b1);
		issue_command(ACT_TICK, 32'd20100, 16'd0, 1'b1);
		issue_command(ACT_CAL, 32'd20200, 16'd0, 1'b1);
		issue_command(ACT_TICK, 32'd60000, 16'd0, 1'b1);
		issue_command(ACT_CAL, 32'd60100, 16'd0, 1'b1);
		issue_command(ACT_CAL, 32'd60200, 16'd0, 1'b1);
		issue_command(ACT_SPARE_LO, 32'd60300, 16'hAAAA, 1'b1);
		issue_command(ACT_SPARE_HI, 32'd60400, 16'h5555, 1'b1);
		issue_command(ACT_SET, 32'd60500, 16'd26200, 1'b1);
		issue_command(ACT_TICK, 32'd80200, 16'd0, 1'b1);
		issue_command(ACT_TICK, 32'd580200, 16'd0, 1'b1);
		issue_command(ACT_TICK, 32'd600200, 16'd0, 1'b1);
		issue_command(ACT_TOGGLE, 32'd600300, 16'd0, 1'b1);
		issue_command(ACT_TOGGLE, 32'hFFFF_FFF0, 16'd0, 1'b1);
		issue_command(ACT_TICK, 32'h0000_4E10, 16'd0, 1'b1);
		stamp_us = 32'h0000_4E10;

		load_profile(16'd1000, 16'd250, 32'd40, 32'd8);
		run_phase(300, 20, 60);
		load_profile(16'hFFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
		run_phase(100, 50, -1);
		load_profile(16'd0, 16'd1, 32'hFFFF_FFFF, 32'd1);
		run_phase(80, 10, -1);
		// a zero step never moves, a zero interval steps on every event
		load_profile(16'd300, 16'd0, 32'd5, 32'd0);
		run_phase(50, 10, -1);
		for (r = 0; r < 2; r++) begin
			load_profile(W_THR'($urandom_range(200, 3000)), W_THR'($urandom_range(1, 400)),
				$urandom_range(0, 60), $urandom_range(1, 16));
			run_phase(140, 24, -1);
		end
		load_profile(16'd40000, 16'd5000, 32'd100000, 32'd20000);
		quiet = 1'b1;
		run_phase(150, 25000, -1);

		for (k = 0; k < 2000 && tracker.expected_q.size() != 0; k++) @(negedge clk);
		repeat (10) @(negedge clk);
		while (tracker.expected_q.size() != 0) begin
			tracker.report_mismatch("missing result, throttle",
				-1, tracker.expected_q[0].throttle_out);
			void'(tracker.expected_q.pop_front());
		end
		if (tracker.errors == 0) begin
			$display("throttle_trapezoid_ramp_sequencer_top verification clean");
		end else begin
			$display("throttle_trapezoid_ramp_sequencer_top verification failed");
		end
		$finish;
	end

endmodule
